// ----- hw/rtl/adcd_pkg.sv -----
// Shared constants, register indexes and the median-of-three helper for the
// converter-sample decimator. No dependencies.
`default_nettype none

package adcd_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int FACTOR_W           = 5;
  localparam int CFG_IDX_W          = 1;
  localparam int CFG_DATA_W         = 5;
  localparam int MAX_DECIMATION_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIAN = 1'd1;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // middle value of three samples
  function automatic sample_t mid_of_three(input sample_t a, input sample_t b,
                                           input sample_t c);
    sample_t lo;
    sample_t hi;
    begin
      lo = (a > b) ? b : a;
      hi = (a > b) ? a : b;
      if (c >= hi) begin
        mid_of_three = hi;
      end else if (c <= lo) begin
        mid_of_three = lo;
      end else begin
        mid_of_three = c;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/adc_sample_decimator_top.sv -----
// Top level of the converter-sample decimator: group sequencer, registers
// and output stage. Uses adcd_pkg and the divider adcd_div.
//
//  port group | dir | payload                                  | handshake
//  in_*       | in  | tdata[15:0] raw_sample, tlast eoc        | tvalid/tready
//  out_*      | out | tdata[15:0] decimated_sample, tlast last  | tvalid/tready
//  cfg_*      | in  | idx 0 decimation_factor, 1 median_mode    | cfg_we
//
// Pass-through and median results go from the result register to the output
// register; a mean first takes the 16+clog2(factor limit) steps of the
// bit-serial divider, and no sample is taken until the result is written.
// Reset is synchronous, active low; factor resets to 1, median mode to 1.
// A waiting result sits in the output register while new requests are taken;
// the sequencer stalls only when a second result is ready before it drains.
`default_nettype none

module adc_sample_decimator_top #(
  parameter int MAX_DECIMATION = adcd_pkg::MAX_DECIMATION_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [15:0]                    in_tdata,   // [15:0] raw_sample
  input  wire logic                           in_tlast,   // end_of_capture
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [15:0]                         out_tdata,  // [15:0] decimated_sample
  output logic                                out_tlast,  // last_of_capture
  input  wire logic                           cfg_we,
  input  wire logic [adcd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [adcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FMAX = (MAX_DECIMATION < 31) ? MAX_DECIMATION : 31;
  localparam int CW   = $clog2(FMAX + 1);
  localparam int SW   = adcd_pkg::SAMPLE_W + $clog2(FMAX);
  localparam logic [adcd_pkg::FACTOR_W-1:0] FMAX_F = adcd_pkg::FACTOR_W'(FMAX);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [adcd_pkg::FACTOR_W-1:0] factor_r, factor_nxt;
  logic                          median_r, median_nxt;
  logic [SW-1:0]                 sum_r, sum_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  adcd_pkg::sample_t             held0_r, held0_nxt;
  adcd_pkg::sample_t             held1_r, held1_nxt;
  adcd_pkg::sample_t             res_r, res_nxt;
  logic                          res_last_r, res_last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  adcd_pkg::sample_t             out_data_r, out_data_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [CW-1:0]      eff;
  logic               accept;
  logic               out_free;
  adcd_pkg::sample_t  sample;
  logic [SW-1:0]      sum_add;
  logic [CW-1:0]      count_add;
  logic               div_start;
  logic [SW-1:0]      div_dividend;
  logic               div_done;
  logic [SW-1:0]      div_quotient;

  always_comb begin
    if (factor_r == '0) begin
      eff = CW'(1);
    end else if (factor_r > FMAX_F) begin
      eff = CW'(FMAX);
    end else begin
      eff = factor_r[CW-1:0];
    end
  end

  assign sample    = in_tdata;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign sum_add   = sum_r + SW'(sample);
  assign count_add = count_r + 1'b1;
  assign div_dividend = sum_add + SW'(eff >> 1);

  always_comb begin
    state_nxt     = state_r;
    factor_nxt    = factor_r;
    median_nxt    = median_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    res_nxt       = res_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;

    if (cfg_we) begin
      if (cfg_idx == adcd_pkg::REG_FACTOR) begin
        factor_nxt = cfg_wdata[adcd_pkg::FACTOR_W-1:0];
        sum_nxt    = '0;
        count_nxt  = '0;
        held0_nxt  = '0;
        held1_nxt  = '0;
      end else if (cfg_idx == adcd_pkg::REG_MEDIAN) begin
        median_nxt = cfg_wdata[0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_last_nxt = in_tlast;
          if (eff == CW'(1)) begin
            res_nxt   = sample;
            sum_nxt   = '0;
            count_nxt = '0;
            held0_nxt = '0;
            held1_nxt = '0;
            state_nxt = ST_WRITE;
          end else if (count_add < eff) begin
            if (in_tlast) begin
              // drop the partial group
              sum_nxt   = '0;
              count_nxt = '0;
              held0_nxt = '0;
              held1_nxt = '0;
            end else begin
              sum_nxt   = sum_add;
              count_nxt = count_add;
              if (count_r == '0) begin
                held0_nxt = sample;
              end
              if (count_r == CW'(1)) begin
                held1_nxt = sample;
              end
            end
          end else begin
            sum_nxt   = '0;
            count_nxt = '0;
            held0_nxt = '0;
            held1_nxt = '0;
            if (median_r && (eff == CW'(3))) begin
              res_nxt   = adcd_pkg::mid_of_three(held0_r, held1_r, sample);
              state_nxt = ST_WRITE;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_quotient[adcd_pkg::SAMPLE_W-1:0];
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // hold the result until the output register drains
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_last_nxt  = res_last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      factor_r    <= adcd_pkg::FACTOR_RESET;
      median_r    <= 1'b1;
      sum_r       <= '0;
      count_r     <= '0;
      held0_r     <= '0;
      held1_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      factor_r    <= factor_nxt;
      median_r    <= median_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    res_last_r <= res_last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  adcd_div #(
    .DVD_W (SW),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/adcd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the decimator mean.
// Depends on nothing outside this file.
`default_nettype none

module adcd_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      // shift in the next dividend bit, subtract where it fits
      rem_nxt  = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- bench/tb_adc_sample_decimator_top.sv -----
// Self-checking bench for adc_sample_decimator_top: random stream traffic with idling on
// both sides, a scoreboard that predicts each decimated sample, and register changes
// between phases. Depends on adcd_pkg and the decimator RTL.

typedef struct {
  adcd_pkg::sample_t value;
  logic              last;
} decim_out_t;

class decim_scoreboard;
  logic [adcd_pkg::FACTOR_W-1:0] factor_q;
  logic                          median_q;
  logic [19:0]                   sum_q;
  logic [4:0]                    count_q;
  adcd_pkg::sample_t             held_q [2];
  decim_out_t                    awaited_outputs [$];
  int                            fail_count;
  int                            reported;

  function new();
    factor_q   = adcd_pkg::FACTOR_RESET;
    median_q   = 1'b1;
    fail_count = 0;
    reported   = 0;
    clear_group();
  endfunction

  function void clear_group();
    sum_q     = '0;
    count_q   = '0;
    held_q[0] = '0;
    held_q[1] = '0;
  endfunction

  function int unsigned eff_factor();
    int unsigned f;
    f = factor_q;
    if (f == 0) f = 1;
    if (f > adcd_pkg::MAX_DECIMATION_DEF) f = adcd_pkg::MAX_DECIMATION_DEF;
    return f;
  endfunction

  function void write_reg(logic [adcd_pkg::CFG_IDX_W-1:0] idx,
                          logic [adcd_pkg::CFG_DATA_W-1:0] val);
    if (idx == adcd_pkg::REG_FACTOR) begin
      factor_q = val;
      clear_group();
    end else if (idx == adcd_pkg::REG_MEDIAN) begin
      median_q = val[0];
    end
  endfunction

  // middle value: total minus the extremes
  function adcd_pkg::sample_t median3(adcd_pkg::sample_t a, adcd_pkg::sample_t b,
                                      adcd_pkg::sample_t c);
    adcd_pkg::sample_t hi;
    adcd_pkg::sample_t lo;
    logic [17:0]       total;
    hi = a;
    lo = a;
    if (b > hi) hi = b;
    if (c > hi) hi = c;
    if (b < lo) lo = b;
    if (c < lo) lo = c;
    total = a + b + c - hi - lo;
    return total[15:0];
  endfunction

  function void take_raw_sample(adcd_pkg::sample_t s, logic eoc);
    int unsigned f;
    int unsigned mean;
    decim_out_t  r;
    f = eff_factor();
    if (f == 1) begin
      clear_group();
      r.value = s;
      r.last  = eoc;
      awaited_outputs.push_back(r);
      return;
    end
    if (count_q < 2) held_q[count_q[0]] = s;
    sum_q   = sum_q + s;
    count_q = count_q + 5'd1;
    if (count_q < f) begin
      // drop the partial group at the end of a capture
      if (eoc) clear_group();
      return;
    end
    if (median_q && f == 3) begin
      r.value = median3(held_q[0], held_q[1], s);
    end else begin
      mean    = (sum_q + f / 2) / f;
      r.value = mean[15:0];
    end
    r.last = eoc;
    clear_group();
    awaited_outputs.push_back(r);
  endfunction

  function void check_decimated(adcd_pkg::sample_t got, logic got_last);
    decim_out_t e;
    if (awaited_outputs.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("unexpected output: value %0d last %0b", got, got_last);
      end
      return;
    end
    e = awaited_outputs.pop_front();
    if (got !== e.value || got_last !== e.last) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                 e.value, e.last, got, got_last);
      end
    end
  endfunction

  function int pending();
    return awaited_outputs.size();
  endfunction
endclass

module tb_adc_sample_decimator_top;
  localparam int SAMPLE_TARGET = 1800;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int FORCED_PHASES = 8;
  localparam int HOLD_PHASE    = 2;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [15:0]                       in_tdata;   // [15:0] raw_sample
  logic                              in_tlast;   // end_of_capture
  logic                              out_tvalid;
  logic                              out_tready;
  logic [15:0]                       out_tdata;  // [15:0] decimated_sample
  logic                              out_tlast;  // last_of_capture
  logic                              cfg_we;
  logic [adcd_pkg::CFG_IDX_W-1:0]    cfg_idx;
  logic [adcd_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  decim_scoreboard sb;
  int              samples_sent;
  bit              tx_idle;
  bit              rx_idle;
  bit              rx_hold_req;

  adc_sample_decimator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_decimated(out_tdata, out_tlast);
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic [15:0] s, input logic eoc);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= eoc;
    do @(posedge clk); while (!in_tready);
    sb.take_raw_sample(s, eoc);
    samples_sent++;
    @(negedge clk);
  endtask

  // hold the input until every request has produced its output, then wait out the settle time
  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [adcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [adcd_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [4:0] pick_factor();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 5'($urandom_range(1, 4));
    if (pick < 8) return 5'($urandom_range(5, 16));
    if (pick < 9) return 5'($urandom_range(17, 31));
    return 5'd0;
  endfunction

  initial begin
    logic [4:0]  forced_f [FORCED_PHASES];
    logic        forced_m [FORCED_PHASES];
    logic [4:0]  f_val;
    logic        m_val;
    bit          wr_f;
    bit          wr_m;
    int          phase;
    int          budget;
    int          kind;
    int          len;
    int unsigned ef;

    forced_f = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd3, 5'd3, 5'd2, 5'd17};
    forced_m = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    sb           = new();
    samples_sent = 0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rx_hold_req  = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = adcd_pkg::REG_FACTOR;
    cfg_wdata    = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pass-through at the reset setting, extremes of the sample
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    drain_and_idle();
    // factor zero behaves as one
    write_cfg(adcd_pkg::REG_FACTOR, 5'd0);
    send_sample(16'h5A5A, 1'b1);
    drain_and_idle();
    // median of three, completed on the end-of-capture sample
    write_cfg(adcd_pkg::REG_FACTOR, 5'd3);
    send_sample(16'd5, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b1);
    // partial group dropped at the end of a capture
    send_sample(16'd100, 1'b0);
    send_sample(16'd200, 1'b1);
    // median mode changed mid-group keeps the partial group
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    drain_and_idle();
    write_cfg(adcd_pkg::REG_MEDIAN, 5'd0);
    send_sample(16'd30, 1'b0);
    // factor rewritten mid-group discards it
    send_sample(16'd40, 1'b0);
    drain_and_idle();
    write_cfg(adcd_pkg::REG_FACTOR, 5'd2);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // rounding of the mean
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);

    phase = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      drain_and_idle();
      if (phase < FORCED_PHASES) begin
        f_val = forced_f[phase];
        m_val = forced_m[phase];
        wr_f  = 1'b1;
        wr_m  = 1'b1;
      end else begin
        f_val = pick_factor();
        m_val = 1'($urandom_range(0, 1));
        wr_f  = $urandom_range(0, 3) != 0;
        wr_m  = $urandom_range(0, 1) != 0;
      end
      if (wr_f) write_cfg(adcd_pkg::REG_FACTOR, f_val);
      if (wr_m) write_cfg(adcd_pkg::REG_MEDIAN, {4'd0, m_val});
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if (phase == HOLD_PHASE) rx_hold_req = 1'b1;
      ef     = sb.eff_factor();
      budget = $urandom_range(30, 90);
      while (budget > 0) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // a multiple of the factor in samples, closed by an end-of-capture mark
          len = ef * $urandom_range(1, 4);
          for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
        end else if (kind < 9) begin
          len = $urandom_range(1, 2 * ef + 1);
          for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
        end else begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) send_sample(rand_sample(), 1'($urandom_range(0, 1)));
        end
        budget -= len;
      end
      phase++;
    end

    drain_and_idle();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout waiting for decimator outputs");
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- adc_sample_decimator_top.f -----
hw/rtl/adcd_pkg.sv
hw/rtl/adcd_div.sv
hw/rtl/adc_sample_decimator_top.sv
bench/tb_adc_sample_decimator_top.sv
